[rtl/idc_pkg.sv]
// ----------------------------------------------------------------------------
// idc_pkg: shared types and constants
// word layouts, status codes, register indexes and the month length table
// ----------------------------------------------------------------------------
package idc_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 7;
  localparam int DAY_W   = 7;
  localparam int POS_W   = 4;

  localparam logic [POS_W-1:0] POS_MAX    = 4'd15;
  localparam logic [POS_W-1:0] DATE_LEN   = 4'd10;
  localparam logic [POS_W-1:0] DASH_POS_A = 4'd4;
  localparam logic [POS_W-1:0] DASH_POS_B = 4'd7;
  localparam logic [POS_W-1:0] YEAR_LO_POS = 4'd2;

  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // result status codes
  localparam logic [1:0] ST_ACCEPTED   = 2'd0;
  localparam logic [1:0] ST_BAD_FORMAT = 2'd1;
  localparam logic [1:0] ST_IMPOSSIBLE = 2'd2;
  localparam logic [1:0] ST_PAST       = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_TODAY_YEAR  = 2'd0;
  localparam logic [1:0] CFG_TODAY_MONTH = 2'd1;
  localparam logic [1:0] CFG_TODAY_DAY   = 2'd2;

  localparam logic [YEAR_W-1:0] RST_TODAY_YEAR  = 14'd2000;
  localparam logic [3:0]        RST_TODAY_MONTH = 4'd1;
  localparam logic [4:0]        RST_TODAY_DAY   = 5'd1;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } out_t;

  // finished date handed from the parser to the checker
  typedef struct packed {
    logic               fmt_bad;
    logic               leap;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [3:0]        month;
    logic [4:0]        day;
  } today_t;

  // days in a month, zero for a month that does not exist
  function automatic logic [4:0] month_days(input logic [MONTH_W-1:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: d = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    d = 5'd30;
      7'd2:                                       d = leap ? 5'd29 : 5'd28;
      default:                                    d = 5'd0;
    endcase
    return d;
  endfunction

endpackage

[rtl/idc_parse.sv]
// ----------------------------------------------------------------------------
// idc_parse: character parser
// tracks position and format, accumulates year, month and day digits and
// hands a finished date word to the checker on the last character
// ----------------------------------------------------------------------------
module idc_parse (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  idc_pkg::in_t   in_word,
  input  logic           date_take,
  output logic           date_valid,
  output idc_pkg::date_t date_word
);

  logic [idc_pkg::POS_W-1:0]   position;
  logic                        format_error;
  logic [idc_pkg::YEAR_W-1:0]  year_acc;
  logic [idc_pkg::MONTH_W-1:0] month_acc;
  logic [idc_pkg::DAY_W-1:0]   day_acc;
  // leap year helpers: century digits mod 4, low two digits mod 4 and nonzero
  logic [1:0]                  hi_mod4;
  logic [1:0]                  lo_mod4;
  logic                        lo_nz;

  logic [idc_pkg::POS_W-1:0]   position_next;
  logic                        format_error_next;
  logic [idc_pkg::YEAR_W-1:0]  year_acc_next;
  logic [idc_pkg::MONTH_W-1:0] month_acc_next;
  logic [idc_pkg::DAY_W-1:0]   day_acc_next;
  logic [1:0]                  hi_mod4_next;
  logic [1:0]                  lo_mod4_next;
  logic                        lo_nz_next;

  logic       accept;
  logic       finish;
  logic       is_digit;
  logic [3:0] digit_val;
  logic [7:0] char_off;

  assign in_stall = date_valid && !date_take;
  assign accept   = in_valid && !in_stall;
  assign finish   = accept && in_word.last;

  assign is_digit  = in_word.character inside {[idc_pkg::CHAR_ZERO:idc_pkg::CHAR_NINE]};
  assign char_off  = in_word.character - idc_pkg::CHAR_ZERO;
  assign digit_val = char_off[3:0];

  always_comb begin
    format_error_next = format_error;
    year_acc_next     = year_acc;
    month_acc_next    = month_acc;
    day_acc_next      = day_acc;
    hi_mod4_next      = hi_mod4;
    lo_mod4_next      = lo_mod4;
    lo_nz_next        = lo_nz;
    if (position >= idc_pkg::DATE_LEN) begin
      format_error_next = 1'b1;
    end else if (position == idc_pkg::DASH_POS_A || position == idc_pkg::DASH_POS_B) begin
      if (in_word.character != idc_pkg::CHAR_DASH) format_error_next = 1'b1;
    end else if (!is_digit) begin
      format_error_next = 1'b1;
    end else if (position < idc_pkg::DASH_POS_A) begin
      year_acc_next = idc_pkg::YEAR_W'((year_acc << 3) + (year_acc << 1)
                                       + idc_pkg::YEAR_W'(digit_val));
      // 10 mod 4 is 2
      if (position < idc_pkg::YEAR_LO_POS) begin
        hi_mod4_next = 2'({hi_mod4[0], 1'b0} + digit_val[1:0]);
      end else begin
        lo_mod4_next = 2'({lo_mod4[0], 1'b0} + digit_val[1:0]);
        lo_nz_next   = lo_nz || (digit_val != 4'd0);
      end
    end else if (position < idc_pkg::DASH_POS_B) begin
      month_acc_next = idc_pkg::MONTH_W'((month_acc << 3) + (month_acc << 1)
                                         + idc_pkg::MONTH_W'(digit_val));
    end else begin
      day_acc_next = idc_pkg::DAY_W'((day_acc << 3) + (day_acc << 1)
                                     + idc_pkg::DAY_W'(digit_val));
    end
    position_next = (position == idc_pkg::POS_MAX) ? position
                                                   : idc_pkg::POS_W'(position + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      format_error <= 1'b0;
      year_acc     <= '0;
      month_acc    <= '0;
      day_acc      <= '0;
      hi_mod4      <= '0;
      lo_mod4      <= '0;
      lo_nz        <= 1'b0;
    end else if (finish) begin
      position     <= '0;
      format_error <= 1'b0;
      year_acc     <= '0;
      month_acc    <= '0;
      day_acc      <= '0;
      hi_mod4      <= '0;
      lo_mod4      <= '0;
      lo_nz        <= 1'b0;
    end else if (accept) begin
      position     <= position_next;
      format_error <= format_error_next;
      year_acc     <= year_acc_next;
      month_acc    <= month_acc_next;
      day_acc      <= day_acc_next;
      hi_mod4      <= hi_mod4_next;
      lo_mod4      <= lo_mod4_next;
      lo_nz        <= lo_nz_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      date_valid <= 1'b0;
    end else if (finish) begin
      date_valid <= 1'b1;
    end else if (date_take) begin
      date_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      date_word.fmt_bad <= format_error_next || (position_next != idc_pkg::DATE_LEN);
      // divisible by 100 only when the low digits are zero, then check the century
      date_word.leap    <= lo_nz_next ? (lo_mod4_next == 2'd0) : (hi_mod4_next == 2'd0);
      date_word.year    <= year_acc_next;
      date_word.month   <= month_acc_next;
      date_word.day     <= day_acc_next;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> date_valid)
    else $error("parser stalls with empty date register");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    finish |=> (position == '0) && !format_error)
    else $error("parser state not cleared after last character");

  a_date_held: assert property (@(posedge clk) disable iff (rst)
    (date_valid && !date_take) |=> date_valid && $stable(date_word))
    else $error("pending date word lost or changed");

endmodule

[rtl/idc_judge.sv]
// ----------------------------------------------------------------------------
// idc_judge: date checker and result register
// classifies a finished date against the calendar and today, holds the result
// ----------------------------------------------------------------------------
module idc_judge (
  input  logic            clk,
  input  logic            rst,
  input  logic            date_valid,
  input  idc_pkg::date_t  date_word,
  output logic            date_take,
  input  idc_pkg::today_t today,
  output logic            out_valid,
  input  logic            out_stall,
  output idc_pkg::out_t   out_word
);

  logic          possible;
  logic          past;
  logic [4:0]    limit;
  logic          load;
  idc_pkg::out_t result;

  assign date_take = !out_valid || !out_stall;
  assign load      = date_valid && date_take;

  assign limit    = idc_pkg::month_days(date_word.month, date_word.leap);
  assign possible = (limit != 5'd0) && (date_word.day != '0)
                    && (date_word.day <= idc_pkg::DAY_W'(limit));

  always_comb begin
    if (date_word.year != today.year) begin
      past = date_word.year < today.year;
    end else if (date_word.month != idc_pkg::MONTH_W'(today.month)) begin
      past = date_word.month < idc_pkg::MONTH_W'(today.month);
    end else begin
      past = date_word.day < idc_pkg::DAY_W'(today.day);
    end
  end

  always_comb begin
    result.year  = date_word.year;
    result.month = date_word.month;
    result.day   = date_word.day;
    if (date_word.fmt_bad) begin
      result.status = idc_pkg::ST_BAD_FORMAT;
      result.year   = '0;
      result.month  = '0;
      result.day    = '0;
    end else if (!possible) begin
      result.status = idc_pkg::ST_IMPOSSIBLE;
    end else if (past) begin
      result.status = idc_pkg::ST_PAST;
    end else begin
      result.status = idc_pkg::ST_ACCEPTED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_word <= result;
  end

  a_bad_format_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.status == idc_pkg::ST_BAD_FORMAT)
      |-> (out_word.year == '0) && (out_word.month == '0) && (out_word.day == '0))
    else $error("bad format result carries date fields");

  a_take_when_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> date_take)
    else $error("checker refuses date with empty result register");

endmodule

[rtl/iso_date_deadline_checker_top.sv]
// ----------------------------------------------------------------------------
// iso_date_deadline_checker_top: YYYY-MM-DD deadline checker
// a finished date is registered in the parser's date word, then in the checker's result register
// throughput: one character word per cycle while in_stall is low, set by the parser's per-character update
// reset clears parser state and the valid flags; today resets to 2000-01-01
// only a word with last set gives a result; the rest give none
// ----------------------------------------------------------------------------
module iso_date_deadline_checker_top (
  input  logic          clk,
  input  logic          rst,
  // character words
  input  logic          in_valid,
  output logic          in_stall,
  input  idc_pkg::in_t  in_word,
  // result words
  output logic          out_valid,
  input  logic          out_stall,
  output idc_pkg::out_t out_word,
  // configuration writes
  input  logic          cfg_write,
  input  logic [1:0]    cfg_index,
  input  logic [13:0]   cfg_data
);

  // today's date, written through the configuration port
  idc_pkg::today_t today;

  // parser to checker hand-off
  logic           date_valid;
  logic           date_take;
  idc_pkg::date_t date_word;

  // register writes, an unused index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      today.year  <= idc_pkg::RST_TODAY_YEAR;
      today.month <= idc_pkg::RST_TODAY_MONTH;
      today.day   <= idc_pkg::RST_TODAY_DAY;
    end else if (cfg_write) begin
      case (cfg_index)
        idc_pkg::CFG_TODAY_YEAR:  today.year  <= cfg_data;
        idc_pkg::CFG_TODAY_MONTH: today.month <= cfg_data[3:0];
        idc_pkg::CFG_TODAY_DAY:   today.day   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // per-character format check and digit accumulation
  idc_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .date_take  (date_take),
    .date_valid (date_valid),
    .date_word  (date_word)
  );

  // calendar and deadline check, result register toward the sink
  idc_judge u_judge (
    .clk        (clk),
    .rst        (rst),
    .date_valid (date_valid),
    .date_word  (date_word),
    .date_take  (date_take),
    .today      (today),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

  // the input side backs up only when both stages hold a word
  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (date_valid && out_valid && out_stall))
    else $error("input stalled while a stage is free");

  // a result word appears only after a date word was handed over
  a_out_from_date: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(date_valid))
    else $error("result without a finished date");

  // today registers change only on reset or a configuration write
  a_today_by_write: assert property (@(posedge clk) disable iff (rst)
    !$past(cfg_write) && !$past(rst) |-> $stable(today))
    else $error("today changed without a write");

endmodule
